/* hdl/tas_pkg.sv */
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types, codes and constants of the timed action scheduler.
// ----------------------------------------------------------------------------
package tas_pkg;

	localparam int SLOT_W = 6;
	localparam int ID_W   = 16;
	localparam int TIME_W = 32;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_CREATE = 2'd1,
		OP_UPDATE = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CREATED   = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_DELETED   = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FIRED     = 3'd5,
		ST_TICK_DONE = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TICK,
		S_CREATE,
		S_FIND
	} state_t;

	localparam logic [1:0] KIND_EXCHANGE = 2'd2;

	localparam logic [1:0] UNIT_MINUTE = 2'd0;
	localparam logic [1:0] UNIT_HOUR   = 2'd1;
	localparam logic [1:0] UNIT_DAY    = 2'd2;

	localparam int SEC_W = 17;
	localparam logic [SEC_W-1:0] SEC_MINUTE = SEC_W'(60);
	localparam logic [SEC_W-1:0] SEC_HOUR   = SEC_W'(60 * 60);
	localparam logic [SEC_W-1:0] SEC_DAY    = SEC_W'(24 * 60 * 60);

	localparam int PERIOD_W = 7 + SEC_W;

	// One table entry as it sits in the slot memory.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [1:0]        kind;
		logic [7:0]        repeat_count;
		logic [1:0]        unit;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [TIME_W-1:0] last_run;
	} slot_entry_t;

	// Firing decision leaving the due pipeline.
	typedef struct packed {
		logic              valid;
		logic              fire;
		logic [SLOT_W-1:0] slot;
	} due_s2_t;

	function automatic logic [SEC_W-1:0] unit_seconds(input logic [1:0] unit);
		logic [SEC_W-1:0] sec;
		unique case (unit)
			UNIT_MINUTE: sec = SEC_MINUTE;
			UNIT_HOUR:   sec = SEC_HOUR;
			UNIT_DAY:    sec = SEC_DAY;
			default:     sec = '0;
		endcase
		return sec;
	endfunction

endpackage

/* hdl/tas_ram.sv */
// ----------------------------------------------------------------------------
// tas_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/tas_due.sv */
// ----------------------------------------------------------------------------
// tas_due
// Two-stage firing check for one slot entry read during a tick walk.
// ----------------------------------------------------------------------------
module tas_due (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_vld,
	input  logic [tas_pkg::SLOT_W-1:0]       in_slot,
	input  logic                             in_en,
	input  tas_pkg::slot_entry_t             entry,
	input  logic [tas_pkg::TIME_W-1:0]       now,
	input  logic                             plate,
	output tas_pkg::due_s2_t                 due,
	output tas_pkg::slot_entry_t             entry_out
);

	logic                                exch;
	logic                                elig;
	logic [tas_pkg::PERIOD_W-1:0]        period;

	logic                                vld_s2;
	logic                                elig_s2;
	logic                                once_s2;
	logic                                last0_s2;
	logic                                start0_s2;
	logic [tas_pkg::PERIOD_W-1:0]        period_s2;
	logic [tas_pkg::SLOT_W-1:0]          slot_s2;
	tas_pkg::slot_entry_t                entry_s2;

	logic [tas_pkg::TIME_W-1:0]          next_run;
	logic                                is_due;

	// Stage 1: kind against plate mode, time window, period product.
	always_comb begin
		exch   = (entry.kind == tas_pkg::KIND_EXCHANGE);
		elig   = in_en && (exch ^ plate) && (now >= entry.start_time) &&
			((entry.end_time == '0) || (now <= entry.end_time));
		period = tas_pkg::PERIOD_W'(entry.repeat_count[6:0]) *
			tas_pkg::PERIOD_W'(tas_pkg::unit_seconds(entry.unit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			elig_s2   <= elig;
			once_s2   <= entry.repeat_count[7];
			last0_s2  <= (entry.last_run == '0);
			start0_s2 <= (entry.start_time == '0);
			period_s2 <= period;
			slot_s2   <= in_slot;
			entry_s2  <= entry;
		end
	end

	// Stage 2: next due time and the compare against now.
	always_comb begin
		if (last0_s2) begin
			next_run = start0_s2 ? now : entry_s2.start_time;
		end else begin
			next_run = entry_s2.last_run + tas_pkg::TIME_W'(period_s2);
		end
		if (once_s2) begin
			is_due = last0_s2;
		end else begin
			is_due = (period_s2 != '0) && (now >= next_run);
		end
		due.valid = vld_s2;
		due.fire  = vld_s2 && elig_s2 && is_due;
		due.slot  = slot_s2;
	end

	assign entry_out = entry_s2;

endmodule

/* hdl/timed_action_scheduler_top.sv */
// ----------------------------------------------------------------------------
// timed_action_scheduler_top
// Table of scheduled actions: create, update, delete and a timed tick walk.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  request  | in        | req_valid/req_stall  | operation, action_id, action_kind,
//           |           |                      | repeat_count, time_unit, start_time,
//           |           |                      | end_time, now_time
//  result   | out       | rsp_valid/rsp_stall  | status, result_id, result_slot,
//           |           |                      | fired_kind, last
//  config   | in        | APB psel/penable     | plate_is_96 at byte address 0
//
//  One request at a time. A tick walks the slots with one slot read per cycle
//  while the result side is free, through the slot RAM port and the two-stage
//  firing check, and ends with its done result. Create scans the enable bits,
//  one per cycle while the result side is free; update and delete search for
//  the identifier through the RAM read port. The state returns to idle as the
//  final result is loaded. Reset clears the enable bits, live count, index and
//  handshakes and sets the next identifier to 1 at once; no clearing pass. A
//  stalled result halts the walk in place, RAM read data included.
// ----------------------------------------------------------------------------
module timed_action_scheduler_top #(
	parameter int ACTION_SLOTS = 32
) (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,

	input  logic         req_valid,
	output logic         req_stall,
	input  logic [1:0]   operation,
	input  logic [15:0]  action_id,
	input  logic [1:0]   action_kind,
	input  logic signed [7:0] repeat_count,
	input  logic [1:0]   time_unit,
	input  logic [31:0]  start_time,
	input  logic [31:0]  end_time,
	input  logic [31:0]  now_time,

	output logic         rsp_valid,
	input  logic         rsp_stall,
	output logic [2:0]   status,
	output logic [15:0]  result_id,
	output logic [5:0]   result_slot,
	output logic [1:0]   fired_kind,
	output logic         last
);

	localparam int IDX_W   = (ACTION_SLOTS > 1) ? $clog2(ACTION_SLOTS) : 1;
	localparam int CNT_W   = $clog2(ACTION_SLOTS + 1);
	localparam int ENTRY_W = $bits(tas_pkg::slot_entry_t);
	localparam logic REG_PLATE = 1'b0;

	// Configuration register
	logic plate_q;

	// Latched request
	tas_pkg::op_t               op_q;
	logic [tas_pkg::ID_W-1:0]   id_q;
	logic [1:0]                 kind_q;
	logic [7:0]                 rep_q;
	logic [1:0]                 unit_q;
	logic [tas_pkg::TIME_W-1:0] start_q;
	logic [tas_pkg::TIME_W-1:0] end_q;
	logic [tas_pkg::TIME_W-1:0] now_q;

	// Control state
	tas_pkg::state_t            state_q, state_nxt;
	logic [ACTION_SLOTS-1:0]    slot_en_q;
	logic [tas_pkg::ID_W-1:0]   next_id_q;
	logic [tas_pkg::SLOT_W-1:0] live_cnt_q;
	logic [CNT_W-1:0]           idx_q;
	logic                       s1_vld_q;
	logic [IDX_W-1:0]           s1_slot_q;

	// Result register
	logic                        rsp_valid_q;
	tas_pkg::status_t            rsp_status_q;
	logic [tas_pkg::ID_W-1:0]    rsp_id_q;
	logic [tas_pkg::SLOT_W-1:0]  rsp_slot_q;
	logic [1:0]                  rsp_kind_q;
	logic                        rsp_last_q;

	// RAM ports
	logic                  rd_en;
	logic [ENTRY_W-1:0]    rd_data;
	tas_pkg::slot_entry_t  rd_entry;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	tas_pkg::slot_entry_t  wr_data;

	// Due pipeline
	tas_pkg::due_s2_t      due;
	tas_pkg::slot_entry_t  due_entry;

	// Step controls
	logic                        accept;
	logic                        adv;
	logic                        walk_more;
	logic                        hit;
	logic                        tick_end;
	logic                        find_miss;
	logic                        cr_full;
	logic                        cr_free;
	logic                        idx_step;
	logic                        set_en;
	logic                        clr_en;
	logic [IDX_W-1:0]            en_addr;
	logic                        id_inc;
	logic                        ld_vld;
	tas_pkg::status_t            ld_status;
	logic [tas_pkg::ID_W-1:0]    ld_id;
	logic [tas_pkg::SLOT_W-1:0]  ld_slot;
	logic [1:0]                  ld_kind;
	logic                        ld_last;

	// ------------------------------------------------------------------
	// Configuration port: one register, no wait states.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PLATE) ? {31'b0, plate_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plate_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PLATE)) begin
			plate_q <= pwdata[0];
		end
	end

	// ------------------------------------------------------------------
	// Handshakes. The walk advances only when the result register can
	// take a new result.
	// ------------------------------------------------------------------
	assign req_stall = (state_q != tas_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign adv       = !rsp_valid_q || !rsp_stall;

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign result_id   = rsp_id_q;
	assign result_slot = rsp_slot_q;
	assign fired_kind  = rsp_kind_q;
	assign last        = rsp_last_q;

	// ------------------------------------------------------------------
	// Slot memory and the firing check behind it
	// ------------------------------------------------------------------
	tas_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ACTION_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	assign rd_entry = rd_data;

	tas_due u_due (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (s1_vld_q && (state_q == tas_pkg::S_TICK)),
		.in_slot   (tas_pkg::SLOT_W'(s1_slot_q)),
		.in_en     (slot_en_q[s1_slot_q]),
		.entry     (rd_entry),
		.now       (now_q),
		.plate     (plate_q),
		.due       (due),
		.entry_out (due_entry)
	);

	// ------------------------------------------------------------------
	// Walk conditions
	// ------------------------------------------------------------------
	assign walk_more = (idx_q < CNT_W'(ACTION_SLOTS));
	// Lowest enabled slot holding the identifier: reads come back in order.
	assign hit       = s1_vld_q && slot_en_q[s1_slot_q] && (rd_entry.id == id_q);
	assign find_miss = !walk_more && !s1_vld_q;
	assign tick_end  = !walk_more && !s1_vld_q && !due.valid;
	assign cr_full   = (live_cnt_q >= tas_pkg::SLOT_W'(ACTION_SLOTS)) || !walk_more;
	assign cr_free   = walk_more && !slot_en_q[idx_q[IDX_W-1:0]];

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tas_pkg::S_IDLE: begin
				if (req_valid) begin
					unique case (tas_pkg::op_t'(operation))
						tas_pkg::OP_TICK:   state_nxt = tas_pkg::S_TICK;
						tas_pkg::OP_CREATE: state_nxt = tas_pkg::S_CREATE;
						default:            state_nxt = tas_pkg::S_FIND;
					endcase
				end
			end
			tas_pkg::S_CREATE: begin
				if (adv && (cr_full || cr_free)) state_nxt = tas_pkg::S_IDLE;
			end
			tas_pkg::S_FIND: begin
				if (adv && (hit || find_miss)) state_nxt = tas_pkg::S_IDLE;
			end
			tas_pkg::S_TICK: begin
				if (adv && tick_end) state_nxt = tas_pkg::S_IDLE;
			end
			default: state_nxt = tas_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Step outputs: RAM accesses, enable bit updates, result loads
	// ------------------------------------------------------------------
	always_comb begin
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = idx_q[IDX_W-1:0];
		wr_data   = rd_entry;
		idx_step  = 1'b0;
		set_en    = 1'b0;
		clr_en    = 1'b0;
		en_addr   = idx_q[IDX_W-1:0];
		id_inc    = 1'b0;
		ld_vld    = 1'b0;
		ld_status = tas_pkg::ST_TICK_DONE;
		ld_id     = '0;
		ld_slot   = '0;
		ld_kind   = '0;
		ld_last   = 1'b1;
		unique case (state_q)
			tas_pkg::S_IDLE: begin
			end
			tas_pkg::S_CREATE: begin
				if (adv) begin
					if (cr_full) begin
						ld_vld    = 1'b1;
						ld_status = tas_pkg::ST_FULL;
					end else if (cr_free) begin
						// Fresh entry, never run.
						wr_en                = 1'b1;
						wr_data.id           = next_id_q;
						wr_data.kind         = kind_q;
						wr_data.repeat_count = rep_q;
						wr_data.unit         = unit_q;
						wr_data.start_time   = start_q;
						wr_data.end_time     = end_q;
						wr_data.last_run     = '0;
						set_en               = 1'b1;
						id_inc               = 1'b1;
						ld_vld               = 1'b1;
						ld_status            = tas_pkg::ST_CREATED;
						ld_id                = next_id_q;
						ld_slot              = tas_pkg::SLOT_W'(idx_q);
					end else begin
						idx_step = 1'b1;
					end
				end
			end
			tas_pkg::S_FIND: begin
				if (adv) begin
					if (hit) begin
						ld_vld  = 1'b1;
						ld_id   = id_q;
						en_addr = s1_slot_q;
						if (op_q == tas_pkg::OP_UPDATE) begin
							// Keep identifier and last run, rewrite the rest.
							wr_en                = 1'b1;
							wr_addr              = s1_slot_q;
							wr_data.kind         = kind_q;
							wr_data.repeat_count = rep_q;
							wr_data.unit         = unit_q;
							wr_data.start_time   = start_q;
							wr_data.end_time     = end_q;
							ld_status            = tas_pkg::ST_UPDATED;
						end else begin
							clr_en    = 1'b1;
							ld_status = tas_pkg::ST_DELETED;
						end
					end else if (find_miss) begin
						ld_vld    = 1'b1;
						ld_status = tas_pkg::ST_NOT_FOUND;
					end else begin
						rd_en = walk_more;
					end
				end
			end
			tas_pkg::S_TICK: begin
				if (adv) begin
					rd_en = walk_more;
					if (due.fire) begin
						// Record the run time and report the firing.
						wr_en            = 1'b1;
						wr_addr          = due.slot[IDX_W-1:0];
						wr_data          = due_entry;
						wr_data.last_run = now_q;
						ld_vld           = 1'b1;
						ld_status        = tas_pkg::ST_FIRED;
						ld_id            = due_entry.id;
						ld_slot          = due.slot;
						ld_kind          = due_entry.kind;
						ld_last          = 1'b0;
					end else if (tick_end) begin
						ld_vld    = 1'b1;
						ld_status = tas_pkg::ST_TICK_DONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tas_pkg::S_IDLE;
			slot_en_q   <= '0;
			next_id_q   <= tas_pkg::ID_W'(1);
			live_cnt_q  <= '0;
			idx_q       <= '0;
			s1_vld_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en || idx_step) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			// Hold the read stage while the result side is stalled.
			if (adv) begin
				s1_vld_q    <= rd_en;
				rsp_valid_q <= ld_vld;
			end
			if (set_en) begin
				slot_en_q[en_addr] <= 1'b1;
				live_cnt_q         <= live_cnt_q + tas_pkg::SLOT_W'(1);
			end
			if (clr_en) begin
				slot_en_q[en_addr] <= 1'b0;
				if (live_cnt_q != '0) begin
					live_cnt_q <= live_cnt_q - tas_pkg::SLOT_W'(1);
				end
			end
			if (id_inc) begin
				next_id_q <= next_id_q + tas_pkg::ID_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= tas_pkg::op_t'(operation);
			id_q    <= action_id;
			kind_q  <= action_kind;
			rep_q   <= repeat_count;
			unit_q  <= time_unit;
			start_q <= start_time;
			end_q   <= end_time;
			now_q   <= now_time;
		end
		if (rd_en) begin
			s1_slot_q <= idx_q[IDX_W-1:0];
		end
		if (adv && ld_vld) begin
			rsp_status_q <= ld_status;
			rsp_id_q     <= ld_id;
			rsp_slot_q   <= ld_slot;
			rsp_kind_q   <= ld_kind;
			rsp_last_q   <= ld_last;
		end
	end

endmodule
